// ===== src/modular_inverse_ext_euclid_unit_assert.svh =====
// Assertion macros shared by the modular inverse unit.
`ifndef MODULAR_INVERSE_EXT_EUCLID_UNIT_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_UNIT_ASSERT_SVH

// Clocked check, masked while reset is held.
`define MIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MIE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mie_pkg.sv =====
// Shared types for the modular inverse unit.
`default_nettype none

package mie_pkg;

  // Status of the shared divide / multiply-accumulate unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== src/mie_div_unit.sv =====
// Bit-serial restoring divider with a shift-add product of quotient and multiplier.
`default_nettype none

module mie_div_unit #(
  parameter int WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WIDTH-1:0]  dividend,
  input  wire logic [WIDTH-1:0]  divisor,   // nonzero, held stable while busy
  input  wire logic [WIDTH-1:0]  mult,      // held stable while busy
  output mie_pkg::div_stat_t     stat,
  output logic      [WIDTH-1:0]  rem,       // dividend % divisor, valid with done
  output logic      [WIDTH-1:0]  prod       // (quotient * mult) mod 2^WIDTH
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [WIDTH-1:0] dvd_r,  dvd_nxt;
  logic [WIDTH-1:0] rem_r,  rem_nxt;
  logic [WIDTH-1:0] acc_r,  acc_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;

  // One quotient bit per cycle, MSB first; product built by Horner's rule.
  assign trial = {rem_r, dvd_r[WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = ~diff[WIDTH];

  always_comb begin
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = CNT_W'(WIDTH);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[WIDTH-2:0], 1'b0};
      rem_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      acc_nxt = {acc_r[WIDTH-2:0], 1'b0} + (ge ? mult : '0);
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;
  assign prod      = acc_r;

endmodule

`default_nettype wire

// ===== src/modular_inverse_ext_euclid_unit.sv =====
// Top level: extended Euclidean modular inverse with one shared serial divider.
//
// Usage:
//   Input channel (in_*): one transaction carries operand and modulus.
//   Output channel (out_*): one transaction per input, carrying the inverse
//   (Bezout coefficient of operand, raised by modulus when negative) and the
//   gcd. The inverse is meaningful only when gcd == 1.
// Sequence: out_tvalid rises after k Euclid iterations (k <= 46 at
//   WIDTH = 32) and S_FINISH. Each iteration is one pass of the
//   bit-serial divider, one quotient bit per cycle, plus a test state
//   (S_CHECK) and the divider's done flag, on which the pairs are updated.
// Flow: one transaction at a time; in_tready is high only in idle, so
//   a new input is not taken until the previous one has been computed.
//   A finished result waits in the output register, so a new input can be
//   taken while the receiver has not yet accepted the previous result.
// Stall: if the receiver still holds off the prior result when the next one
//   is finished, the sequencer waits in its finish state.
// Reset: synchronous, active low; returns to idle with no output valid.
// Zero modulus: inverse 1, gcd = operand, via S_CHECK and S_FINISH with no divide.
`default_nettype none

module modular_inverse_ext_euclid_unit #(
  parameter int WIDTH = 32,
  localparam int TDATA_W = ((2 * WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // operand, modulus, zero pad
  // result channel
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [TDATA_W-1:0] out_tdata   // inverse, gcd, zero pad
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,   // test remainder for zero, launch divider
    S_DIV,     // divider running; update pairs when done
    S_FINISH   // sign fix, load output register
  } state_t;

  state_t           state_r,      state_nxt;
  logic [WIDTH-1:0] r_prev_r,     r_prev_nxt;
  logic [WIDTH-1:0] r_cur_r,      r_cur_nxt;
  logic [WIDTH-1:0] m_prev_r,     m_prev_nxt;
  logic [WIDTH-1:0] m_cur_r,      m_cur_nxt;
  logic [WIDTH-1:0] n_r,          n_nxt;
  logic             neg_r,        neg_nxt;
  logic             out_valid_r,  out_valid_nxt;
  logic [WIDTH-1:0] inv_r,        inv_nxt;
  logic [WIDTH-1:0] gcd_r,        gcd_nxt;

  logic               div_start;
  mie_pkg::div_stat_t div_stat;
  logic [WIDTH-1:0]   div_rem;
  logic [WIDTH-1:0]   div_prod;
  logic               in_fire;
  logic               out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign div_start = (state_r == S_CHECK) && (r_cur_r != '0);

  // Shared unit: r_prev / r_cur, with quotient * m_cur accumulated alongside.
  mie_div_unit #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (r_prev_r),
    .divisor  (r_cur_r),
    .mult     (m_cur_r),
    .stat     (div_stat),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  always_comb begin
    state_nxt     = state_r;
    r_prev_nxt    = r_prev_r;
    r_cur_nxt     = r_cur_r;
    m_prev_nxt    = m_prev_r;
    m_cur_nxt     = m_cur_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    inv_nxt       = inv_r;
    gcd_nxt       = gcd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          r_prev_nxt = in_tdata[WIDTH-1:0];
          r_cur_nxt  = in_tdata[2*WIDTH-1:WIDTH];
          n_nxt      = in_tdata[2*WIDTH-1:WIDTH];
          m_prev_nxt = WIDTH'(1);
          m_cur_nxt  = '0;
          neg_nxt    = 1'b0;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = (r_cur_r == '0) ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          r_prev_nxt = r_cur_r;
          r_cur_nxt  = div_rem;
          m_prev_nxt = m_cur_r;
          m_cur_nxt  = m_prev_r + div_prod;
          neg_nxt    = !neg_r;
          state_nxt  = S_CHECK;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          // negative coefficient is raised by the modulus once
          inv_nxt       = (neg_r && (m_prev_r != '0)) ? (n_r - m_prev_r) : m_prev_r;
          gcd_nxt       = r_prev_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r_prev_r <= r_prev_nxt;
    r_cur_r  <= r_cur_nxt;
    m_prev_r <= m_prev_nxt;
    m_cur_r  <= m_cur_nxt;
    n_r      <= n_nxt;
    neg_r    <= neg_nxt;
    inv_r    <= inv_nxt;
    gcd_r    <= gcd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({gcd_r, inv_r});

`include "modular_inverse_ext_euclid_unit_assert.svh"

  `MIE_ASSERT(a_no_accept_while_div, in_fire |-> !div_stat.busy, "input taken while divider busy")
  `MIE_ASSERT(a_done_in_div, div_stat.done |-> (state_r == S_DIV), "divider done outside divide state")
  `MIE_ASSERT(a_zero_rem_ends, (state_r == S_CHECK) && (r_cur_r == '0) |=> (state_r == S_FINISH), "zero remainder did not end loop")
  `MIE_ASSERT(a_out_from_finish, $rose(out_valid_r) |-> ($past(state_r) == S_FINISH), "result raised outside finish state")
  `MIE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r, "not idle after reset")

endmodule

`default_nettype wire

// ===== verif/modular_inverse_ext_euclid_unit_test.sv =====
// Self-checking testbench for the extended Euclidean modular inverse unit.
`timescale 1ns / 100ps

module modular_inverse_ext_euclid_unit_test;

  localparam int          WIDTH        = 32;
  localparam int          TDATA_W      = 64;
  localparam bit [63:0]   COEF_MASK    = 64'h0000_0000_FFFF_FFFF;
  localparam bit [31:0]   ALL_ONES     = 32'hFFFF_FFFF;
  // Above the slowest item plus the random idling on each side.
  localparam int          IDLE_LIMIT   = 10000;
  // Longest single computation, waited out after the last result.
  localparam int          DRAIN_CYCLES = 2000;
  localparam int          RANDOM_ITEMS = 380;

  typedef struct {
    bit [31:0] operand;
    bit [31:0] modulus;
    bit [31:0] inverse;
    bit [31:0] gcd;
  } inverse_expect_t;

  // Holds predicted (inverse, gcd) pairs in input order and checks results.
  class inverse_scoreboard;
    inverse_expect_t expected_q[$];
    int errors;
    int checked;
    int noted;

    // Euclid on (operand, modulus), tracking only the operand's coefficient
    // as a magnitude plus a sign that flips every iteration.
    function automatic void compute_inverse(input bit [31:0] operand, input bit [31:0] modulus,
                                            output bit [31:0] inverse, output bit [31:0] gcd);
      bit [63:0] r_prev;
      bit [63:0] r_cur;
      bit [63:0] r_next;
      bit [63:0] c_prev;
      bit [63:0] c_cur;
      bit [63:0] c_next;
      bit [63:0] quo;
      bit        prev_neg;
      r_prev   = {32'b0, operand};
      r_cur    = {32'b0, modulus};
      c_prev   = 64'd1;
      c_cur    = 64'd0;
      prev_neg = 1'b0;
      while (r_cur != 64'd0) begin
        quo      = r_prev / r_cur;
        r_next   = r_prev - quo * r_cur;
        c_next   = (c_prev + quo * c_cur) & COEF_MASK;
        r_prev   = r_cur;
        r_cur    = r_next;
        c_prev   = c_cur;
        c_cur    = c_next;
        prev_neg = !prev_neg;
      end
      // negative coefficient gets the modulus added once
      if (prev_neg && c_prev != 64'd0)
        inverse = 32'(({32'b0, modulus} - c_prev) & COEF_MASK);
      else
        inverse = c_prev[31:0];
      gcd = r_prev[31:0];
    endfunction

    function void note_operands(bit [31:0] operand, bit [31:0] modulus);
      inverse_expect_t e;
      e.operand = operand;
      e.modulus = modulus;
      compute_inverse(operand, modulus, e.inverse, e.gcd);
      expected_q.push_back(e);
      noted++;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bit [31:0] inverse, bit [31:0] gcd);
      inverse_expect_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: inverse=%h gcd=%h",
                                  inverse, gcd));
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (inverse !== e.inverse)
          report_mismatch($sformatf("a=%h n=%h inverse got %h want %h",
                                    e.operand, e.modulus, inverse, e.inverse));
        if (gcd !== e.gcd)
          report_mismatch($sformatf("a=%h n=%h gcd got %h want %h",
                                    e.operand, e.modulus, gcd, e.gcd));
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT hookup
  // ---------------------------------------------------------------------------
  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [TDATA_W-1:0] in_tdata   = '0;   // operand, modulus
  logic               out_tready = 1'b0;
  wire                in_tready;
  wire                out_tvalid;
  wire  [TDATA_W-1:0] out_tdata;         // inverse, gcd

  // when set, neither side idles (back-to-back stretches)
  bit                 no_idle = 1'b0;
  int                 idle_cycles = 0;
  int                 directed_count = 0;
  int                 sent_items = 0;
  bit [31:0]          fib [48];

  inverse_scoreboard  sb = new;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  modular_inverse_ext_euclid_unit #(.WIDTH(WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Monitors and watchdog. Values read here are the pre-edge ones, so each
  // handshake is seen exactly as the DUT sees it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_operands(in_tdata[31:0], in_tdata[63:32]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[31:0], out_tdata[63:32]);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results pending",
               IDLE_LIMIT, sb.expected_q.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: hold out_tready low for a random stall before each transaction.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Drive one operand pair; returns at the edge where it was accepted.
  // tvalid is only dropped when a gap follows, so back-to-back items keep it high.
  task automatic send_operands(input bit [31:0] operand, input bit [31:0] modulus);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {modulus, operand};
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  // One random pair, weighted toward the cases that stress the loop.
  task automatic send_random_pair();
    bit [31:0] a;
    bit [31:0] n;
    bit [31:0] g;
    int        k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin  // full-range values, mostly coprime
        a = $urandom;
        n = $urandom;
      end
      5: begin              // small values, short loops
        a = $urandom_range(0, 255);
        n = $urandom_range(0, 255);
      end
      6: begin              // shared factor, gcd above one
        g = $urandom_range(2, 1000);
        a = g * $urandom_range(0, 32'h3F_FFFF);
        n = g * $urandom_range(1, 32'h3F_FFFF);
      end
      7: begin              // operand one below the modulus
        n = $urandom;
        a = n - 1;
      end
      8: begin              // consecutive Fibonacci numbers, longest loops
        k = $urandom_range(1, 46);
        if ($urandom_range(0, 1)) begin
          a = fib[k];
          n = fib[k+1];
        end else begin
          a = fib[k+1];
          n = fib[k];
        end
      end
      default: begin        // zeros, all-ones or random values in either field
        a = $urandom_range(0, 1) ? 32'd0 : ($urandom_range(0, 1) ? ALL_ONES : $urandom);
        n = $urandom_range(0, 1) ? 32'd0 : ($urandom_range(0, 1) ? ALL_ONES : $urandom);
      end
    endcase
    send_operands(a, n);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    fib[0] = 32'd0;
    fib[1] = 32'd1;
    for (int i = 2; i < 48; i++)
      fib[i] = fib[i-1] + fib[i-2];

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero fields, ones, extremes, gcd above one, deepest loop
    send_operands(32'd0,        32'd0);
    send_operands(32'd0,        32'd1);
    send_operands(32'd0,        ALL_ONES);
    send_operands(ALL_ONES,     32'd0);
    send_operands(32'd5,        32'd0);
    send_operands(32'd1,        32'd1);
    send_operands(32'd1,        ALL_ONES);
    send_operands(ALL_ONES,     32'd1);
    send_operands(ALL_ONES,     ALL_ONES);
    send_operands(ALL_ONES,     ALL_ONES - 1);
    send_operands(ALL_ONES - 1, ALL_ONES);
    send_operands(32'd3,        32'd7);
    send_operands(32'd10,       32'd7);
    send_operands(32'd7,        32'd7);
    send_operands(32'd12,       32'd18);
    send_operands(32'd18,       32'd12);
    send_operands(32'd2,        32'h8000_0000);
    send_operands(32'h8000_0000, ALL_ONES);
    send_operands(fib[46],      fib[47]);
    send_operands(fib[47],      fib[46]);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    directed_count = sent_items;

    // random: every fourth block of 50 runs without any idling
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = ((i / 50) % 4) == 3;
      send_random_pair();
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d operand pairs (%0d directed: zero fields, extremes, gcd > 1,",
             sb.noted, directed_count);
    $display("  deepest Fibonacci loops) with random idling; %0d results checked",
             sb.checked);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
